### hdl/axrot_pkg.sv
// Shared widths and the CORDIC arctangent table for the axis-angle rotation pipeline.
package axrot_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 16;
  localparam int AXIS_WIDTH   = 16;
  localparam int CORDIC_STEPS = 30;

  // CORDIC datapath: x and y in Q2.30 with headroom, z in 2^32 units per turn.
  localparam int XW = 34;
  localparam int ZW = 33;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [XW:0]   ONE_Q30     = 35'sd1073741824;

  // Matrix datapath widths.
  localparam int BW   = XW + 1;                 // b = 1 - c
  localparam int UW   = 2 * AXIS_WIDTH;         // axis product
  localparam int BHW  = BW - 16;                // upper part of b
  localparam int BHPW = BHW + UW;
  localparam int BLPW = 17 + UW;
  localparam int BFW  = BHPW + 16;
  localparam int NPW  = XW + AXIS_WIDTH;
  localparam int TW   = 36;                     // one b or n term
  localparam int MW   = 37;                     // one matrix entry

  // Row product widths; the point is split at bit 24.
  localparam int PHW  = COORD_WIDTH - 24;
  localparam int HPW  = PHW + MW;
  localparam int LPW  = 25 + MW;
  localparam int HSW  = HPW + 2;
  localparam int LSW  = LPW + 2;
  localparam int SW   = HSW + 1;
  localparam int RW   = SW - 6;

  localparam int NSTG = CORDIC_STEPS + 6;

  localparam logic signed [ZW-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
    33'sd21354465, 33'sd10679838, 33'sd5340245, 33'sd2670163, 33'sd1335087,
    33'sd667544, 33'sd333772, 33'sd166886, 33'sd83443, 33'sd41722,
    33'sd20861, 33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
    33'sd652, 33'sd326, 33'sd163, 33'sd81, 33'sd41,
    33'sd20, 33'sd10, 33'sd5, 33'sd3, 33'sd1
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] px;
    logic signed [COORD_WIDTH-1:0] py;
    logic signed [COORD_WIDTH-1:0] pz;
    logic signed [AXIS_WIDTH-1:0]  ax;
    logic signed [AXIS_WIDTH-1:0]  ay;
    logic signed [AXIS_WIDTH-1:0]  az;
    logic                          flip;
  } carry_t;

endpackage

### hdl/axis_angle_point_rotation.sv
// Pipeline: 31 CORDIC stages, 4 matrix stages and 1 output register lie
// between an accepted input word and its output word.
// Throughput: one word per cycle; the whole pipeline holds while out_stall is
// high and a result is waiting, and in_stall follows from that.
// Reset (rst, synchronous) clears every valid bit; the datapath is not reset.
// The output register holds the saturated point and the clipped flag.
module axis_angle_point_rotation import axrot_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [AXIS_WIDTH-1:0]  axis_x,
  input  logic signed [AXIS_WIDTH-1:0]  axis_y,
  input  logic signed [AXIS_WIDTH-1:0]  axis_z,
  input  logic [ANGLE_WIDTH-1:0]        turn_angle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic signed [COORD_WIDTH-1:0] rotated_z,
  output logic                          clipped
);

  logic [NSTG-1:0] vld;
  logic            adv;

  assign adv       = !vld[NSTG-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // Angle folding: angles in the middle half turn are moved by half a turn
  // and the CORDIC result is negated afterwards.
  logic [31:0]     ang_w;
  logic            ang_flip;
  logic [31:0]     ang_f;

  assign ang_w    = {turn_angle, {(32 - ANGLE_WIDTH){1'b0}}};
  assign ang_flip = ang_w[31] ^ ang_w[30];
  assign ang_f    = {ang_w[31] ^ ang_flip, ang_w[30:0]};

  logic signed [XW-1:0] cx [CORDIC_STEPS+1];
  logic signed [XW-1:0] cy [CORDIC_STEPS+1];
  logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
  carry_t               cc [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= CORDIC_GAIN;
      cy[0] <= '0;
      cz[0] <= ZW'($signed(ang_f));
      cc[0] <= '{px: point_x, py: point_y, pz: point_z,
                 ax: axis_x, ay: axis_y, az: axis_z, flip: ang_flip};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - dx;
          cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - ATAN_TURNS[i];
        end else begin
          cx[i+1] <= cx[i] + dx;
          cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + ATAN_TURNS[i];
        end
        cc[i+1] <= cc[i];
      end
    end
  end

  // Stage M1: cosine, negated sine n, b = 1 - c, axis products and n * axis.
  carry_t                 k_in;
  logic signed [XW-1:0]   c_w;
  logic signed [XW-1:0]   n_w;
  logic signed [BW-1:0]   b_w;

  assign k_in = cc[CORDIC_STEPS];
  assign c_w  = k_in.flip ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  assign n_w  = k_in.flip ? cy[CORDIC_STEPS] : -cy[CORDIC_STEPS];
  assign b_w  = ONE_Q30 - BW'(c_w);

  carry_t                m1_k;
  logic signed [XW-1:0]  m1_c;
  logic signed [BW-1:0]  m1_b;
  logic signed [UW-1:0]  m1_uw [6];
  logic signed [NPW-1:0] m1_nu [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_k     <= k_in;
      m1_c     <= c_w;
      m1_b     <= b_w;
      m1_uw[0] <= k_in.ax * k_in.ax;
      m1_uw[1] <= k_in.ay * k_in.ay;
      m1_uw[2] <= k_in.az * k_in.az;
      m1_uw[3] <= k_in.ax * k_in.ay;
      m1_uw[4] <= k_in.ax * k_in.az;
      m1_uw[5] <= k_in.ay * k_in.az;
      m1_nu[0] <= NPW'(n_w) * NPW'(k_in.ax);
      m1_nu[1] <= NPW'(n_w) * NPW'(k_in.ay);
      m1_nu[2] <= NPW'(n_w) * NPW'(k_in.az);
    end
  end

  // Stage M2: b times axis products as two partial products; scaled n terms.
  logic signed [BHW-1:0] b_hi;
  logic signed [16:0]    b_lo;

  assign b_hi = m1_b[BW-1:16];
  assign b_lo = $signed({1'b0, m1_b[15:0]});

  carry_t                 m2_k;
  logic signed [XW-1:0]   m2_c;
  logic signed [BHPW-1:0] m2_bh [6];
  logic signed [BLPW-1:0] m2_bl [6];
  logic signed [TW-1:0]   m2_nt [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_k <= m1_k;
      m2_c <= m1_c;
      for (int j = 0; j < 6; j++) begin
        m2_bh[j] <= BHPW'(b_hi) * BHPW'(m1_uw[j]);
        m2_bl[j] <= BLPW'(b_lo) * BLPW'(m1_uw[j]);
      end
      for (int j = 0; j < 3; j++) begin
        m2_nt[j] <= TW'(m1_nu[j] >>> 14);
      end
    end
  end

  // Stage M3: assemble the b terms and the nine matrix entries.
  logic signed [BFW-1:0] bfull [6];
  logic signed [TW-1:0]  bt    [6];
  logic signed [MW-1:0]  cm;
  logic signed [MW-1:0]  mtx   [9];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      bfull[j] = (BFW'(m2_bh[j]) <<< 16) + BFW'(m2_bl[j]);
      bt[j]    = TW'(bfull[j] >>> 28);
    end
    cm     = MW'(m2_c);
    mtx[0] = cm + MW'(bt[0]);
    mtx[1] = MW'(bt[3]) - MW'(m2_nt[2]);
    mtx[2] = MW'(bt[4]) + MW'(m2_nt[1]);
    mtx[3] = MW'(bt[3]) + MW'(m2_nt[2]);
    mtx[4] = cm + MW'(bt[1]);
    mtx[5] = MW'(bt[5]) - MW'(m2_nt[0]);
    mtx[6] = MW'(bt[4]) - MW'(m2_nt[1]);
    mtx[7] = MW'(bt[5]) + MW'(m2_nt[0]);
    mtx[8] = cm + MW'(bt[2]);
  end

  carry_t               m3_k;
  logic signed [MW-1:0] m3_m [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_k <= m2_k;
      m3_m <= mtx;
    end
  end

  // Stage M4: row products, with each coordinate split into a signed upper
  // part and an unsigned 24-bit lower part.
  logic signed [COORD_WIDTH-1:0] pv [3];
  logic signed [HPW-1:0]         m4_ph [9];
  logic signed [LPW-1:0]         m4_pl [9];

  assign pv[0] = m3_k.px;
  assign pv[1] = m3_k.py;
  assign pv[2] = m3_k.pz;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          m4_ph[3*r+k] <= HPW'($signed(pv[k][COORD_WIDTH-1:24])) * HPW'(m3_m[3*r+k]);
          m4_pl[3*r+k] <= LPW'($signed({1'b0, pv[k][23:0]})) * LPW'(m3_m[3*r+k]);
        end
      end
    end
  end

  // Stage M5: sum, round half up, saturate.
  localparam logic signed [RW-1:0] MAXV = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [RW-1:0] MINV = -MAXV - RW'(1);

  logic signed [HSW-1:0]         hs  [3];
  logic signed [LSW-1:0]         ls  [3];
  logic signed [SW-1:0]          sm  [3];
  logic signed [RW-1:0]          rr  [3];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic [2:0]                    sat;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      hs[r] = HSW'(m4_ph[3*r]) + HSW'(m4_ph[3*r+1]) + HSW'(m4_ph[3*r+2]);
      ls[r] = LSW'(m4_pl[3*r]) + LSW'(m4_pl[3*r+1]) + LSW'(m4_pl[3*r+2]);
      sm[r] = SW'(hs[r]) + SW'(ls[r] >>> 24) + SW'(32);
      rr[r] = RW'(sm[r] >>> 6);
      if (rr[r] > MAXV) begin
        res[r] = MAXV[COORD_WIDTH-1:0];
        sat[r] = 1'b1;
      end else if (rr[r] < MINV) begin
        res[r] = MINV[COORD_WIDTH-1:0];
        sat[r] = 1'b1;
      end else begin
        res[r] = rr[r][COORD_WIDTH-1:0];
        sat[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rotated_x <= res[0];
      rotated_y <= res[1];
      rotated_z <= res[2];
      clipped   <= |sat;
    end
  end

endmodule
